// File: hdl/snfcs_pkg.sv
package snfcs_pkg;

  localparam int ADDR_BITS = 24;
  localparam int POLL_BITS = 22;
  localparam int STEPS     = 16;

  // input item kinds
  typedef enum logic [3:0] {
    MODE_WREN     = 4'd0,
    MODE_SECTOR   = 4'd1,
    MODE_BLOCK    = 4'd2,
    MODE_CHIP     = 4'd3,
    MODE_PROGRAM  = 4'd4,
    MODE_READ     = 4'd5,
    MODE_ID       = 4'd6,
    MODE_STATUS   = 4'd7,
    MODE_CAPACITY = 4'd8,
    MODE_DATA     = 4'd9,
    MODE_REPLY    = 4'd10
  } mode_t;

  typedef enum logic [2:0] {
    ACT_SEL   = 3'd0,
    ACT_DESEL = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_RECV  = 3'd3,
    ACT_HOST  = 3'd4,
    ACT_DONE  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WREN_POLL,
    PH_FINAL_POLL,
    PH_PROG_DATA,
    PH_READ_DATA,
    PH_ID_DATA,
    PH_STATUS_DATA,
    PH_CAP_DATA
  } phase_t;

  // flash opcodes
  localparam logic [7:0] OP_WREN    = 8'h06;
  localparam logic [7:0] OP_RDSR    = 8'h05;
  localparam logic [7:0] OP_READ    = 8'h03;
  localparam logic [7:0] OP_PROGRAM = 8'h02;
  localparam logic [7:0] OP_SECTOR  = 8'h20;
  localparam logic [7:0] OP_BLOCK   = 8'hD8;
  localparam logic [7:0] OP_RDID    = 8'h9F;
  localparam logic [7:0] OP_CHIP    = 8'hC7;

  localparam logic [POLL_BITS-1:0] POLL_LIMIT_RST = 22'd2000000;
  localparam logic [POLL_BITS-1:0] POLL_MAX       = '1;

  // fixed slots of a result sequence, emitted in this order
  localparam int S_BYTE   = 0;
  localparam int S_DESEL1 = 1;
  localparam int S_SEL1   = 2;
  localparam int S_OP     = 3;
  localparam int S_A2     = 4;
  localparam int S_A1     = 5;
  localparam int S_A0     = 6;
  localparam int S_DESEL2 = 7;
  localparam int S_SEL2   = 8;
  localparam int S_RDSR   = 9;
  localparam int S_RECV   = 10;
  localparam int S_CAP0   = 11;
  localparam int S_DONE   = 15;

  typedef struct packed {
    logic [3:0]  mode;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_byte;
    logic       timed_out;
    logic       last;
  } out_word_t;

  // one queued job: slot mask plus the bytes it needs
  typedef struct packed {
    logic [STEPS-1:0]     mask;
    logic                 byte_host;
    logic [7:0]           byte_val;
    logic [7:0]           op;
    logic [ADDR_BITS-1:0] addr;
    logic [31:0]          cap;
    logic                 timed_out;
  } job_t;

  // jedec capacity code to byte count
  function automatic logic [31:0] capacity_of(input logic [7:0] d);
    logic [31:0] c;
    case (d)
      8'h11: c = 32'h0002_0000;
      8'h12: c = 32'h0004_0000;
      8'h13: c = 32'h0008_0000;
      8'h14: c = 32'h0010_0000;
      8'h15: c = 32'h0020_0000;
      8'h16: c = 32'h0040_0000;
      8'h17: c = 32'h0080_0000;
      8'h18: c = 32'h0100_0000;
      8'h19: c = 32'h0200_0000;
      8'h20: c = 32'h0400_0000;
      8'h21: c = 32'h0800_0000;
      8'h22: c = 32'h1000_0000;
      8'h23: c = 32'h2000_0000;
      default: c = 32'h0;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/snfcs_front.sv
module snfcs_front #(
  parameter int PAGE_BYTES = 256,
  parameter int ID_BYTES   = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  snfcs_pkg::in_word_t       word,
  input  logic                      cfg_we,
  input  logic [snfcs_pkg::POLL_BITS-1:0] cfg_data,
  output logic                      push,
  output snfcs_pkg::job_t           job
);

  snfcs_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  cmd_r, cmd_nxt;
  logic [snfcs_pkg::ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [15:0] left_r, left_nxt;
  logic [snfcs_pkg::POLL_BITS-1:0] poll_r, poll_nxt, limit_r;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  id2_r;

  logic        is_cmd, is_data, is_reply, in_poll, poll_more, cap_end;
  logic [15:0] left_dec, page_len, id_len, cap_len;
  logic [2:0]  idx_inc;
  logic [7:0]  code;

  // shared decode
  always_comb begin
    is_cmd    = acc && (word.mode <= 4'(snfcs_pkg::MODE_CAPACITY)) &&
                (phase_r == snfcs_pkg::PH_IDLE);
    is_data   = acc && (word.mode == 4'(snfcs_pkg::MODE_DATA)) &&
                (phase_r == snfcs_pkg::PH_PROG_DATA);
    is_reply  = acc && (word.mode == 4'(snfcs_pkg::MODE_REPLY));
    in_poll   = (phase_r == snfcs_pkg::PH_WREN_POLL) ||
                (phase_r == snfcs_pkg::PH_FINAL_POLL);
    poll_more = word.data_byte[0] && !(poll_r > limit_r || poll_r == snfcs_pkg::POLL_MAX);
    left_dec  = left_r - 16'd1;
    idx_inc   = idx_r + 3'd1;
    cap_end   = !(idx_inc < 3'(ID_BYTES));
    code      = (idx_r == 3'd2) ? word.data_byte : id2_r;
    page_len  = (word.length > 16'(PAGE_BYTES)) ? 16'(PAGE_BYTES) : word.length;
    id_len    = (word.length > 16'(ID_BYTES)) ? 16'(ID_BYTES) : word.length;
    cap_len   = (word.length > 16'd4) ? 16'd4 : word.length;
  end

  // phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (is_cmd) begin
      unique case (word.mode) inside
        4'(snfcs_pkg::MODE_WREN), 4'(snfcs_pkg::MODE_SECTOR), 4'(snfcs_pkg::MODE_BLOCK),
        4'(snfcs_pkg::MODE_CHIP), 4'(snfcs_pkg::MODE_PROGRAM):
          phase_nxt = snfcs_pkg::PH_WREN_POLL;
        4'(snfcs_pkg::MODE_READ):
          phase_nxt = (word.length == 16'd0) ? snfcs_pkg::PH_IDLE : snfcs_pkg::PH_READ_DATA;
        4'(snfcs_pkg::MODE_ID):
          phase_nxt = (id_len == 16'd0) ? snfcs_pkg::PH_IDLE : snfcs_pkg::PH_ID_DATA;
        4'(snfcs_pkg::MODE_STATUS): phase_nxt = snfcs_pkg::PH_STATUS_DATA;
        default: phase_nxt = snfcs_pkg::PH_CAP_DATA;
      endcase
    end else if (is_data) begin
      if (left_dec == 16'd0) phase_nxt = snfcs_pkg::PH_FINAL_POLL;
    end else if (is_reply) begin
      unique case (phase_r)
        snfcs_pkg::PH_WREN_POLL: begin
          if (!poll_more) begin
            case (cmd_r)
              4'(snfcs_pkg::MODE_SECTOR), 4'(snfcs_pkg::MODE_BLOCK),
              4'(snfcs_pkg::MODE_CHIP): phase_nxt = snfcs_pkg::PH_FINAL_POLL;
              4'(snfcs_pkg::MODE_PROGRAM):
                phase_nxt = (left_r == 16'd0) ? snfcs_pkg::PH_FINAL_POLL
                                              : snfcs_pkg::PH_PROG_DATA;
              default: phase_nxt = snfcs_pkg::PH_IDLE;
            endcase
          end
        end
        snfcs_pkg::PH_FINAL_POLL: if (!poll_more) phase_nxt = snfcs_pkg::PH_IDLE;
        snfcs_pkg::PH_READ_DATA, snfcs_pkg::PH_ID_DATA:
          if (left_dec == 16'd0) phase_nxt = snfcs_pkg::PH_IDLE;
        snfcs_pkg::PH_STATUS_DATA: phase_nxt = snfcs_pkg::PH_IDLE;
        snfcs_pkg::PH_CAP_DATA: if (cap_end) phase_nxt = snfcs_pkg::PH_IDLE;
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // job build and datapath updates
  always_comb begin
    cmd_nxt  = cmd_r;
    addr_nxt = addr_r;
    left_nxt = left_r;
    poll_nxt = poll_r;
    idx_nxt  = idx_r;
    job      = '0;
    job.byte_val = word.data_byte;
    job.addr     = addr_r;
    job.cap      = snfcs_pkg::capacity_of(code);
    if (is_cmd) begin
      cmd_nxt  = word.mode;
      addr_nxt = word.address;
      job.addr = word.address;
      left_nxt = '0;
      idx_nxt  = '0;
      job.mask[snfcs_pkg::S_SEL1] = 1'b1;
      job.mask[snfcs_pkg::S_OP]   = 1'b1;
      case (word.mode)
        4'(snfcs_pkg::MODE_READ): begin
          job.op = snfcs_pkg::OP_READ;
          job.mask[snfcs_pkg::S_A0:snfcs_pkg::S_A2] = 3'b111;
          left_nxt = word.length;
          if (word.length == 16'd0) begin
            job.mask[snfcs_pkg::S_DESEL2] = 1'b1;
            job.mask[snfcs_pkg::S_DONE]   = 1'b1;
          end else begin
            job.mask[snfcs_pkg::S_RECV] = 1'b1;
          end
        end
        4'(snfcs_pkg::MODE_STATUS): begin
          job.op = snfcs_pkg::OP_RDSR;
          job.mask[snfcs_pkg::S_RECV] = 1'b1;
        end
        4'(snfcs_pkg::MODE_ID): begin
          job.op   = snfcs_pkg::OP_RDID;
          left_nxt = id_len;
          if (id_len == 16'd0) begin
            job.mask[snfcs_pkg::S_DESEL2] = 1'b1;
            job.mask[snfcs_pkg::S_DONE]   = 1'b1;
          end else begin
            job.mask[snfcs_pkg::S_RECV] = 1'b1;
          end
        end
        4'(snfcs_pkg::MODE_CAPACITY): begin
          job.op   = snfcs_pkg::OP_RDID;
          left_nxt = cap_len;
          job.mask[snfcs_pkg::S_RECV] = 1'b1;
        end
        default: begin
          // write enable then busy wait
          job.op   = snfcs_pkg::OP_WREN;
          poll_nxt = '0;
          if (word.mode == 4'(snfcs_pkg::MODE_PROGRAM)) left_nxt = page_len;
          job.mask[snfcs_pkg::S_DESEL2] = 1'b1;
          job.mask[snfcs_pkg::S_SEL2]   = 1'b1;
          job.mask[snfcs_pkg::S_RDSR]   = 1'b1;
          job.mask[snfcs_pkg::S_RECV]   = 1'b1;
        end
      endcase
    end else if (is_data) begin
      left_nxt = left_dec;
      job.mask[snfcs_pkg::S_BYTE] = 1'b1;
      if (left_dec == 16'd0) begin
        poll_nxt = '0;
        job.mask[snfcs_pkg::S_DESEL1] = 1'b1;
        job.mask[snfcs_pkg::S_SEL2]   = 1'b1;
        job.mask[snfcs_pkg::S_RDSR]   = 1'b1;
        job.mask[snfcs_pkg::S_RECV]   = 1'b1;
      end
    end else if (is_reply) begin
      if (in_poll) begin
        if (poll_more) begin
          poll_nxt = poll_r + 1'b1;
          job.mask[snfcs_pkg::S_RECV] = 1'b1;
        end else begin
          job.timed_out = word.data_byte[0];
          job.mask[snfcs_pkg::S_DESEL1] = 1'b1;
          if (phase_r == snfcs_pkg::PH_WREN_POLL &&
              cmd_r >= 4'(snfcs_pkg::MODE_SECTOR) &&
              cmd_r <= 4'(snfcs_pkg::MODE_PROGRAM)) begin
            job.mask[snfcs_pkg::S_SEL1] = 1'b1;
            job.mask[snfcs_pkg::S_OP]   = 1'b1;
            if (cmd_r != 4'(snfcs_pkg::MODE_CHIP))
              job.mask[snfcs_pkg::S_A0:snfcs_pkg::S_A2] = 3'b111;
            case (cmd_r)
              4'(snfcs_pkg::MODE_SECTOR): job.op = snfcs_pkg::OP_SECTOR;
              4'(snfcs_pkg::MODE_BLOCK):  job.op = snfcs_pkg::OP_BLOCK;
              4'(snfcs_pkg::MODE_CHIP):   job.op = snfcs_pkg::OP_CHIP;
              default:                    job.op = snfcs_pkg::OP_PROGRAM;
            endcase
            if (cmd_r != 4'(snfcs_pkg::MODE_PROGRAM) || left_r == 16'd0) begin
              poll_nxt = '0;
              job.mask[snfcs_pkg::S_DESEL2] = 1'b1;
              job.mask[snfcs_pkg::S_SEL2]   = 1'b1;
              job.mask[snfcs_pkg::S_RDSR]   = 1'b1;
              job.mask[snfcs_pkg::S_RECV]   = 1'b1;
            end
          end else begin
            job.mask[snfcs_pkg::S_DONE] = 1'b1;
          end
        end
      end else if (phase_r == snfcs_pkg::PH_READ_DATA || phase_r == snfcs_pkg::PH_ID_DATA) begin
        left_nxt = left_dec;
        job.byte_host = 1'b1;
        job.mask[snfcs_pkg::S_BYTE] = 1'b1;
        if (left_dec == 16'd0) begin
          job.mask[snfcs_pkg::S_DESEL1] = 1'b1;
          job.mask[snfcs_pkg::S_DONE]   = 1'b1;
        end else begin
          job.mask[snfcs_pkg::S_RECV] = 1'b1;
        end
      end else if (phase_r == snfcs_pkg::PH_STATUS_DATA) begin
        job.byte_host = 1'b1;
        job.mask[snfcs_pkg::S_BYTE]   = 1'b1;
        job.mask[snfcs_pkg::S_DESEL1] = 1'b1;
        job.mask[snfcs_pkg::S_DONE]   = 1'b1;
      end else if (phase_r == snfcs_pkg::PH_CAP_DATA) begin
        idx_nxt = idx_inc;
        if (!cap_end) begin
          job.mask[snfcs_pkg::S_RECV] = 1'b1;
        end else begin
          job.mask[snfcs_pkg::S_DESEL1] = 1'b1;
          job.mask[snfcs_pkg::S_DONE]   = 1'b1;
          for (int i = 0; i < 4; i++)
            if (16'(i) < left_r) job.mask[snfcs_pkg::S_CAP0 + i] = 1'b1;
        end
      end
    end
    push = (job.mask != '0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= snfcs_pkg::PH_IDLE;
      cmd_r   <= '0;
      addr_r  <= '0;
      left_r  <= '0;
      poll_r  <= '0;
      idx_r   <= '0;
      limit_r <= snfcs_pkg::POLL_LIMIT_RST;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      poll_r  <= poll_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) limit_r <= cfg_data;
    end
  end

  // third id byte, written before it is read
  always_ff @(posedge clk) begin
    if (is_reply && phase_r == snfcs_pkg::PH_CAP_DATA && idx_r == 3'd2) id2_r <= word.data_byte;
  end

endmodule

// File: hdl/snfcs_queue.sv
module snfcs_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  snfcs_pkg::job_t push_job,
  input  logic            pop,
  output logic            has_job,
  output logic            full,
  output snfcs_pkg::job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  snfcs_pkg::job_t slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // pointer and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_job;
  end

  assign has_job = (cnt_r != '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign head    = slot_r[rp_r];

endmodule

// File: hdl/snfcs_back.sv
module snfcs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 has_job,
  input  snfcs_pkg::job_t      head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output snfcs_pkg::out_word_t out_word
);

  snfcs_pkg::job_t job_r;
  logic [snfcs_pkg::STEPS-1:0] rem_r, rem_nxt, pick;
  logic active_r, active_nxt, ovalid_r, ovalid_nxt, adv;
  logic [3:0] pos;
  snfcs_pkg::out_word_t oword_r, oword_nxt;

  // take the next job once the current one is spent
  assign pop = !active_r && has_job;
  assign adv = active_r && (!ovalid_r || !out_stall);

  // lowest pending slot
  always_comb begin
    pick = rem_r & (~rem_r + 1'b1);
    pos  = '0;
    for (int i = 0; i < snfcs_pkg::STEPS; i++)
      if (pick[i]) pos = 4'(i);
  end

  // result word for the chosen slot
  always_comb begin
    oword_nxt = '0;
    rem_nxt   = rem_r & ~pick;
    case (pos)
      4'(snfcs_pkg::S_BYTE): begin
        oword_nxt.action   = job_r.byte_host ? 3'(snfcs_pkg::ACT_HOST) : 3'(snfcs_pkg::ACT_SEND);
        oword_nxt.bus_byte = job_r.byte_val;
      end
      4'(snfcs_pkg::S_DESEL1), 4'(snfcs_pkg::S_DESEL2):
        oword_nxt.action = 3'(snfcs_pkg::ACT_DESEL);
      4'(snfcs_pkg::S_SEL1), 4'(snfcs_pkg::S_SEL2):
        oword_nxt.action = 3'(snfcs_pkg::ACT_SEL);
      4'(snfcs_pkg::S_OP): begin
        oword_nxt.action   = 3'(snfcs_pkg::ACT_SEND);
        oword_nxt.bus_byte = job_r.op;
      end
      4'(snfcs_pkg::S_A2): begin
        oword_nxt.action   = 3'(snfcs_pkg::ACT_SEND);
        oword_nxt.bus_byte = job_r.addr[23:16];
      end
      4'(snfcs_pkg::S_A1): begin
        oword_nxt.action   = 3'(snfcs_pkg::ACT_SEND);
        oword_nxt.bus_byte = job_r.addr[15:8];
      end
      4'(snfcs_pkg::S_A0): begin
        oword_nxt.action   = 3'(snfcs_pkg::ACT_SEND);
        oword_nxt.bus_byte = job_r.addr[7:0];
      end
      4'(snfcs_pkg::S_RDSR): begin
        oword_nxt.action   = 3'(snfcs_pkg::ACT_SEND);
        oword_nxt.bus_byte = snfcs_pkg::OP_RDSR;
      end
      4'(snfcs_pkg::S_RECV):
        oword_nxt.action = 3'(snfcs_pkg::ACT_RECV);
      4'(snfcs_pkg::S_DONE): begin
        oword_nxt.action    = 3'(snfcs_pkg::ACT_DONE);
        oword_nxt.timed_out = job_r.timed_out;
      end
      default: begin
        // capacity bytes, little endian
        oword_nxt.action   = 3'(snfcs_pkg::ACT_HOST);
        oword_nxt.bus_byte = job_r.cap[8 * (pos - 4'(snfcs_pkg::S_CAP0)) +: 8];
      end
    endcase
    oword_nxt.last = (rem_nxt == '0);
    active_nxt = pop ? 1'b1 : (adv ? (rem_nxt != '0) : active_r);
    ovalid_nxt = adv ? 1'b1 : (ovalid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
      rem_r    <= '0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
      if (pop) rem_r <= head.mask;
      else if (adv) rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= head;
    if (adv) oword_r <= oword_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_word  = oword_r;

endmodule

// File: hdl/spi_nor_flash_command_sequencer.sv
// SPI NOR flash command sequencer.
// Input channel (in_valid/in_stall/in_word) takes host commands, program data
// words and flash reply words; a word is taken when in_valid is high and
// in_stall low. Each word yields zero to ten result words on the output
// channel (out_valid/out_stall/out_word): select, deselect, send, receive,
// host byte and command done; last marks the final result of a word.
// The front end classifies a word and updates the sequencing state, then
// queues a job if the word has results; the back end loads each job from
// the queue and then emits one result a cycle from its output register
// while out_stall is low. The front keeps taking words until the job
// queue is full; in_stall rises when words come faster than the back end
// emits their results, or while out_stall holds the back end.
// cfg_we/cfg_data write the busy poll limit; write only when idle.
// Reset (rst_n low, synchronous) returns to idle, empties the queue and
// restores the poll limit to 2000000.
module spi_nor_flash_command_sequencer #(
  parameter int PAGE_BYTES = 256,
  parameter int ID_BYTES   = 4,
  parameter int Q_DEPTH    = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  snfcs_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output snfcs_pkg::out_word_t out_word,
  input  logic                 cfg_we,
  input  logic [snfcs_pkg::POLL_BITS-1:0] cfg_data
);

  logic acc, push, pop, has_job, full;
  snfcs_pkg::job_t job, head;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  snfcs_front #(.PAGE_BYTES(PAGE_BYTES), .ID_BYTES(ID_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .word(in_word),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .push(push), .job(job)
  );

  snfcs_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(job), .pop(pop),
    .has_job(has_job), .full(full), .head(head)
  );

  snfcs_back u_back (
    .clk(clk), .rst_n(rst_n), .has_job(has_job), .head(head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  // timeout flag only rides on command done
  a_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.timed_out |-> out_word.action == 3'(snfcs_pkg::ACT_DONE))
    else $error("timeout flag on a result other than done");

  // done always closes the results of its word
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.action == 3'(snfcs_pkg::ACT_DONE) |-> out_word.last)
    else $error("done result not marked last");

  // nothing is pushed into a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("job pushed into full queue");

  // reset clears the output
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// File: test/tb_spi_nor_flash_command_sequencer.sv
module tb_spi_nor_flash_command_sequencer;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  snfcs_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  snfcs_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [snfcs_pkg::POLL_BITS-1:0] cfg_data = '0;

  spi_nor_flash_command_sequencer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // words waiting to be sent and results still owed by the block
  snfcs_pkg::in_word_t cmd_words[$];
  snfcs_pkg::out_word_t owed_results[$];
  snfcs_pkg::out_word_t burst[$];
  int snd_idle = 24;
  int rcv_idle = 53;
  logic hold = 1'b0;
  int errors = 0;

  // sequencer shadow state
  logic [snfcs_pkg::POLL_BITS-1:0] poll_lim = snfcs_pkg::POLL_LIMIT_RST;
  snfcs_pkg::phase_t ph = snfcs_pkg::PH_IDLE;
  logic [3:0] cur_cmd = '0;
  logic [23:0] flash_addr = '0;
  logic [15:0] left = '0;
  logic [snfcs_pkg::POLL_BITS-1:0] pcnt = '0;
  logic [7:0] ids[4];
  logic [2:0] bidx = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  function void emit(snfcs_pkg::action_t a, logic [7:0] b, logic to);
    snfcs_pkg::out_word_t r;
    if (burst.size() < 10) begin
      r.action = a;
      r.bus_byte = b;
      r.timed_out = to;
      r.last = 1'b0;
      burst.push_back(r);
    end
  endfunction

  function void send_addr();
    emit(snfcs_pkg::ACT_SEND, flash_addr[23:16], 1'b0);
    emit(snfcs_pkg::ACT_SEND, flash_addr[15:8], 1'b0);
    emit(snfcs_pkg::ACT_SEND, flash_addr[7:0], 1'b0);
  endfunction

  function void start_poll(snfcs_pkg::phase_t p);
    emit(snfcs_pkg::ACT_SEL, 8'h00, 1'b0);
    emit(snfcs_pkg::ACT_SEND, snfcs_pkg::OP_RDSR, 1'b0);
    emit(snfcs_pkg::ACT_RECV, 8'h00, 1'b0);
    pcnt = '0;
    ph = p;
  endfunction

  function void finish_cmd(logic to);
    emit(snfcs_pkg::ACT_DONE, 8'h00, to);
    ph = snfcs_pkg::PH_IDLE;
  endfunction

  // continue an erase or program, or finish a write enable, once the write enable busy wait ends
  function void after_wren(logic to);
    case (cur_cmd)
      snfcs_pkg::MODE_SECTOR, snfcs_pkg::MODE_BLOCK: begin
        emit(snfcs_pkg::ACT_SEL, 8'h00, 1'b0);
        emit(snfcs_pkg::ACT_SEND, cur_cmd == snfcs_pkg::MODE_SECTOR ? snfcs_pkg::OP_SECTOR
                                                                    : snfcs_pkg::OP_BLOCK,
             1'b0);
        send_addr();
        emit(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
        start_poll(snfcs_pkg::PH_FINAL_POLL);
      end
      snfcs_pkg::MODE_CHIP: begin
        emit(snfcs_pkg::ACT_SEL, 8'h00, 1'b0);
        emit(snfcs_pkg::ACT_SEND, snfcs_pkg::OP_CHIP, 1'b0);
        emit(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
        start_poll(snfcs_pkg::PH_FINAL_POLL);
      end
      snfcs_pkg::MODE_PROGRAM: begin
        emit(snfcs_pkg::ACT_SEL, 8'h00, 1'b0);
        emit(snfcs_pkg::ACT_SEND, snfcs_pkg::OP_PROGRAM, 1'b0);
        send_addr();
        if (left == 0) begin
          emit(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
          start_poll(snfcs_pkg::PH_FINAL_POLL);
        end else begin
          ph = snfcs_pkg::PH_PROG_DATA;
        end
      end
      default: finish_cmd(to);
    endcase
  endfunction

  function void poll_reply(logic [7:0] b);
    logic to;
    to = 1'b0;
    if (b[0]) begin
      if (pcnt > poll_lim || pcnt == snfcs_pkg::POLL_MAX) begin
        to = 1'b1;
      end else begin
        pcnt = pcnt + 1'b1;
        emit(snfcs_pkg::ACT_RECV, 8'h00, 1'b0);
        return;
      end
    end
    emit(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
    if (ph == snfcs_pkg::PH_WREN_POLL) after_wren(to);
    else finish_cmd(to);
  endfunction

  function void start_command(snfcs_pkg::in_word_t w);
    cur_cmd = w.mode;
    flash_addr = w.address;
    left = '0;
    bidx = '0;
    emit(snfcs_pkg::ACT_SEL, 8'h00, 1'b0);
    if (w.mode <= snfcs_pkg::MODE_PROGRAM) begin
      if (w.mode == snfcs_pkg::MODE_PROGRAM) left = (w.length > 256) ? 16'd256 : w.length;
      emit(snfcs_pkg::ACT_SEND, snfcs_pkg::OP_WREN, 1'b0);
      emit(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
      start_poll(snfcs_pkg::PH_WREN_POLL);
      return;
    end
    if (w.mode == snfcs_pkg::MODE_READ) begin
      emit(snfcs_pkg::ACT_SEND, snfcs_pkg::OP_READ, 1'b0);
      send_addr();
      left = w.length;
    end else if (w.mode == snfcs_pkg::MODE_STATUS) begin
      emit(snfcs_pkg::ACT_SEND, snfcs_pkg::OP_RDSR, 1'b0);
      emit(snfcs_pkg::ACT_RECV, 8'h00, 1'b0);
      ph = snfcs_pkg::PH_STATUS_DATA;
      return;
    end else begin
      emit(snfcs_pkg::ACT_SEND, snfcs_pkg::OP_RDID, 1'b0);
      left = (w.length > 4) ? 16'd4 : w.length;
    end
    if (w.mode != snfcs_pkg::MODE_CAPACITY && left == 0) begin
      emit(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
      finish_cmd(1'b0);
      return;
    end
    emit(snfcs_pkg::ACT_RECV, 8'h00, 1'b0);
    ph = (w.mode == snfcs_pkg::MODE_READ) ? snfcs_pkg::PH_READ_DATA :
         (w.mode == snfcs_pkg::MODE_ID) ? snfcs_pkg::PH_ID_DATA : snfcs_pkg::PH_CAP_DATA;
  endfunction

  // work out the results of one accepted word
  function void seq_step(snfcs_pkg::in_word_t w);
    logic [31:0] cap;
    burst.delete();
    if (w.mode <= snfcs_pkg::MODE_CAPACITY) begin
      if (ph == snfcs_pkg::PH_IDLE) start_command(w);
    end else if (w.mode == snfcs_pkg::MODE_DATA) begin
      if (ph == snfcs_pkg::PH_PROG_DATA) begin
        emit(snfcs_pkg::ACT_SEND, w.data_byte, 1'b0);
        left = left - 1'b1;
        if (left == 0) begin
          emit(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
          start_poll(snfcs_pkg::PH_FINAL_POLL);
        end
      end
    end else if (w.mode == snfcs_pkg::MODE_REPLY) begin
      case (ph)
        snfcs_pkg::PH_WREN_POLL, snfcs_pkg::PH_FINAL_POLL: poll_reply(w.data_byte);
        snfcs_pkg::PH_READ_DATA, snfcs_pkg::PH_ID_DATA: begin
          emit(snfcs_pkg::ACT_HOST, w.data_byte, 1'b0);
          left = left - 1'b1;
          if (left == 0) begin
            emit(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
            finish_cmd(1'b0);
          end else begin
            emit(snfcs_pkg::ACT_RECV, 8'h00, 1'b0);
          end
        end
        snfcs_pkg::PH_STATUS_DATA: begin
          emit(snfcs_pkg::ACT_HOST, w.data_byte, 1'b0);
          emit(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
          finish_cmd(1'b0);
        end
        snfcs_pkg::PH_CAP_DATA: begin
          ids[bidx[1:0]] = w.data_byte;
          bidx = bidx + 1'b1;
          if (bidx < 4) begin
            emit(snfcs_pkg::ACT_RECV, 8'h00, 1'b0);
          end else begin
            emit(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
            cap = snfcs_pkg::capacity_of(ids[2]);
            for (int i = 0; i < 4 && i < left; i++)
              emit(snfcs_pkg::ACT_HOST, cap[8*i +: 8], 1'b0);
            finish_cmd(1'b0);
          end
        end
        default: ;
      endcase
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) owed_results.push_back(burst[i]);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) seq_step(in_word);
      if (!in_valid || !in_stall) begin
        if (cmd_words.size() > 0 && !hold && $urandom_range(0, 99) >= snd_idle) begin
          in_valid <= 1'b1;
          in_word <= cmd_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    snfcs_pkg::out_word_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result word %h", out_word);
          errors++;
        end else begin
          e = owed_results.pop_front();
          if (out_word.action !== e.action) begin
            $error("action expected %0d actual %0d", e.action, out_word.action);
            errors++;
          end
          if (out_word.bus_byte !== e.bus_byte) begin
            $error("bus_byte expected %h actual %h", e.bus_byte, out_word.bus_byte);
            errors++;
          end
          if (out_word.timed_out !== e.timed_out) begin
            $error("timed_out expected %0d actual %0d", e.timed_out, out_word.timed_out);
            errors++;
          end
          if (out_word.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, out_word.last);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  task put(logic [3:0] m, logic [23:0] a, logic [15:0] l, logic [7:0] d);
    snfcs_pkg::in_word_t w;
    w.mode = m;
    w.address = a;
    w.length = l;
    w.data_byte = d;
    cmd_words.push_back(w);
  endtask

  task put_reply(logic busy);
    logic [7:0] d;
    d = 8'($urandom);
    d[0] = busy;
    put(snfcs_pkg::MODE_REPLY, 24'($urandom), 16'($urandom), d);
  endtask

  // ignored stray words of unused kinds
  task put_stray();
    if ($urandom_range(0, 9) == 0)
      put(4'($urandom_range(11, 15)), 24'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // busy replies then ready, stopping early once the wait has timed out
  task gen_poll();
    int n;
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      put_reply(1'b1);
      put_stray();
      if (i == int'(poll_lim) + 1) return;
    end
    put_reply(1'b0);
  endtask

  task gen_seq(logic [3:0] m, logic [15:0] len);
    logic [7:0] codes[14];
    int k;
    codes = '{8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
              8'h18, 8'h19, 8'h20, 8'h21, 8'h22, 8'h23, 8'h00};
    put(m, 24'($urandom), len, 8'($urandom));
    // a command while busy is dropped
    if (!((m == snfcs_pkg::MODE_READ || m == snfcs_pkg::MODE_ID) && len == 0) &&
        $urandom_range(0, 6) == 0)
      put(4'($urandom_range(0, 8)), 24'($urandom), 16'($urandom), 8'($urandom));
    case (m)
      snfcs_pkg::MODE_WREN: gen_poll();
      snfcs_pkg::MODE_SECTOR, snfcs_pkg::MODE_BLOCK, snfcs_pkg::MODE_CHIP: begin
        gen_poll();
        gen_poll();
      end
      snfcs_pkg::MODE_PROGRAM: begin
        gen_poll();
        k = (len > 256) ? 256 : int'(len);
        for (int i = 0; i < k; i++) begin
          put(snfcs_pkg::MODE_DATA, 24'($urandom), 16'($urandom), 8'($urandom));
          put_stray();
        end
        gen_poll();
      end
      snfcs_pkg::MODE_READ: for (int i = 0; i < len; i++) put_reply(1'($urandom));
      snfcs_pkg::MODE_ID: for (int i = 0; i < len && i < 4; i++) put_reply(1'($urandom));
      snfcs_pkg::MODE_STATUS: put_reply(1'($urandom));
      default: begin
        put_reply(1'($urandom));
        put_reply(1'($urandom));
        if ($urandom_range(0, 3) == 0)
          put(snfcs_pkg::MODE_REPLY, 24'($urandom), 16'($urandom), 8'($urandom));
        else
          put(snfcs_pkg::MODE_REPLY, 24'($urandom), 16'($urandom),
              codes[$urandom_range(0, 13)]);
        put_reply(1'($urandom));
      end
    endcase
    // data and replies while idle are dropped
    if ($urandom_range(0, 9) == 0)
      put(4'($urandom_range(9, 10)), 24'($urandom), 16'($urandom), 8'($urandom));
    put_stray();
  endtask

  task gen_random(int n);
    logic [15:0] len;
    int start;
    start = cmd_words.size();
    while (cmd_words.size() - start < n) begin
      len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 300))
                                        : 16'($urandom_range(0, 6));
      gen_seq(4'($urandom_range(0, 8)), len);
    end
  endtask

  task wait_drained();
    while (cmd_words.size() > 0 || in_valid || owed_results.size() > 0) @(posedge clk);
  endtask

  task set_limit(logic [snfcs_pkg::POLL_BITS-1:0] v);
    wait_drained();
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    poll_lim = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed words
    put(snfcs_pkg::MODE_REPLY, 24'h0, 16'h0, 8'hff);
    put(snfcs_pkg::MODE_DATA, 24'hffffff, 16'hffff, 8'hff);
    put(4'd15, 24'hffffff, 16'hffff, 8'hff);
    gen_seq(snfcs_pkg::MODE_WREN, 16'd0);
    gen_seq(snfcs_pkg::MODE_SECTOR, 16'd0);
    gen_seq(snfcs_pkg::MODE_BLOCK, 16'hffff);
    gen_seq(snfcs_pkg::MODE_CHIP, 16'd0);
    gen_seq(snfcs_pkg::MODE_PROGRAM, 16'd0);
    gen_seq(snfcs_pkg::MODE_PROGRAM, 16'd2);
    gen_seq(snfcs_pkg::MODE_READ, 16'd0);
    gen_seq(snfcs_pkg::MODE_READ, 16'd2);
    gen_seq(snfcs_pkg::MODE_ID, 16'd0);
    gen_seq(snfcs_pkg::MODE_ID, 16'hffff);
    gen_seq(snfcs_pkg::MODE_STATUS, 16'd0);
    gen_seq(snfcs_pkg::MODE_CAPACITY, 16'd0);
    gen_seq(snfcs_pkg::MODE_CAPACITY, 16'hffff);

    set_limit('0);
    gen_random(60);
    repeat (100) @(posedge clk);
    // sender holds off until the block has caught up
    hold <= 1'b1;
    @(posedge clk);
    while (in_valid || owed_results.size() > 0) @(posedge clk);
    hold <= 1'b0;
    gen_random(60);

    set_limit(22'd3);
    snd_idle = 53;
    rcv_idle = 24;
    gen_random(120);

    set_limit(snfcs_pkg::POLL_MAX);
    gen_random(100);

    set_limit(22'd1);
    snd_idle = 0;
    rcv_idle = 0;
    gen_random(120);

    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
